FILE: rtl/vdcd_pkg.sv
// types and constants for the varint delta column decoder
`default_nettype none

package vdcd_pkg;

  typedef enum logic {
    ACT_HEADER = 1'b0,
    ACT_CHUNK  = 1'b1
  } action_e;

  localparam int unsigned WordW     = 32;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned ColOutW   = 2;
  localparam int unsigned RowW      = 31;
  localparam int unsigned ChunkCfgW = 5;
  localparam int unsigned BitPosW   = 6;

  localparam int unsigned InDataW  = WordW;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned OutUserW = 2;

  localparam logic [ChunkCfgW-1:0] ChunkBitsReset = 5'd8;
  localparam logic [ChunkCfgW-1:0] ChunkBitsMin   = 5'd2;
  localparam logic [BitPosW-1:0]   BitPosMax      = 6'd32;
  localparam logic [RowW-1:0]      RowCountMax    = {RowW{1'b1}};

endpackage

`default_nettype wire

FILE: rtl/varint_delta_column_decoder.sv
// varint delta column decoder top level
`default_nettype none

// Decodes sign-magnitude varint chunks into per-column running sums.
// Input stream: tuser[0] = action (0 header, 1 chunk), tdata = 32-bit word.
// A header sets the row count of a block; chunks of chunk_bits+1 bits follow,
// column by column, row by row. Each value with a stop bit yields one result.
// Output stream: tdata = value, column, row; tlast marks the last value of
// the block; tuser = overflow, protocol_error.
// Config channel: cfg_valid_i/cfg_data_i writes chunk_bits, always ready;
// write only while the block is idle.
// The result is registered and appears in the cycle after its chunk transfer.
// Throughput: one item per cycle unless output stalls, set by the single state
// update and the output register; decode is one shift, mask and add per chunk.
// When the receiver stalls with a result held, the input stays ready only
// if that result is taken in the same cycle, so no result is ever dropped.
// Reset clears decode state and tvalid, sets chunk_bits to 8, closes any block.
module varint_delta_column_decoder #(
  parameter int unsigned NUM_COLUMNS = 3,
  parameter int unsigned HEADER_BITS = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [vdcd_pkg::ChunkCfgW-1:0]      cfg_data_i,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] word
  input  wire  [vdcd_pkg::InDataW-1:0]        s_axis_tdata,
  // [0] action
  input  wire  [vdcd_pkg::InUserW-1:0]        s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // [31:0] value, [33:32] column, [64:34] row, [71:65] zero
  output logic [vdcd_pkg::OutDataW-1:0]       m_axis_tdata,
  // last_of_block
  output logic                                m_axis_tlast,
  // [0] overflow, [1] protocol_error
  output logic [vdcd_pkg::OutUserW-1:0]       m_axis_tuser
);
  import vdcd_pkg::*;

  localparam int unsigned ColW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [ColW-1:0] ColLast = ColW'(NUM_COLUMNS - 1);
  localparam logic [WordW-1:0] HdrMask =
    WordW'((64'd1 << HEADER_BITS) - 64'd1);
  localparam int unsigned PadW = OutDataW - ValueW - ColOutW - RowW;

  // state
  logic [ChunkCfgW-1:0] chunk_bits_q;
  logic                 block_open_q, block_open_d;
  logic [RowW-1:0]      rows_q, rows_d;
  logic [RowW-1:0]      row_q, row_d;
  logic [ColW-1:0]      col_q, col_d;
  logic [ValueW-1:0]    mag_q, mag_d;
  logic [BitPosW-1:0]   bitpos_q, bitpos_d;
  logic                 neg_q, neg_d;
  logic                 first_q, first_d;
  logic                 ovf_q, ovf_d;
  logic [ValueW-1:0]    sum_q, sum_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic                 res_load;
  logic [ValueW-1:0]    res_value_q, res_value_d;
  logic [ColOutW-1:0]   res_col_q, res_col_d;
  logic [RowW-1:0]      res_row_q, res_row_d;
  logic                 res_last_q, res_last_d;
  logic                 res_ovf_q, res_ovf_d;
  logic                 res_perr_q, res_perr_d;

  logic                 in_xfer;
  action_e              action;
  logic [WordW-1:0]     word;
  logic [ChunkCfgW-1:0] c;
  logic [ChunkCfgW-1:0] c_m1;
  logic [WordW-1:0]     lo_mask;
  logic [WordW-1:0]     pay_mask;
  logic [WordW-1:0]     payload;
  logic [2*WordW-1:0]   placed;
  logic [BitPosW:0]     bitpos_sum;
  logic [WordW-1:0]     hdr_cnt;
  logic                 stop;
  logic [ValueW-1:0]    delta_x;
  logic [ValueW-1:0]    sum_base;
  logic [WordW-1:0]     row_inc;
  logic                 row_end;
  logic [ColW+ColOutW-1:0] col_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tuser[0]);
  assign word          = s_axis_tdata;

  assign c        = (chunk_bits_q < ChunkBitsMin) ? ChunkBitsMin : chunk_bits_q;
  assign c_m1     = c - ChunkCfgW'(1);
  assign lo_mask  = (WordW'(1) << c_m1) - WordW'(1);
  assign pay_mask = (WordW'(1) << c) - WordW'(1);
  assign payload  = word & pay_mask;
  assign placed   = {{WordW{1'b0}}, payload} << bitpos_q[BitPosW-2:0];
  assign bitpos_sum = {1'b0, bitpos_q} + (BitPosW+1)'(c);
  assign hdr_cnt  = word & HdrMask;
  assign stop     = word[c];
  assign row_inc  = {1'b0, row_q} + WordW'(1);
  assign row_end  = row_inc >= {1'b0, rows_q};
  assign col_ext  = {{ColOutW{1'b0}}, col_q};

  always_comb begin
    block_open_d = block_open_q;
    rows_d       = rows_q;
    row_d        = row_q;
    col_d        = col_q;
    mag_d        = mag_q;
    bitpos_d     = bitpos_q;
    neg_d        = neg_q;
    first_d      = first_q;
    ovf_d        = ovf_q;
    sum_d        = sum_q;
    res_load     = 1'b0;
    res_value_d  = '0;
    res_col_d    = '0;
    res_row_d    = '0;
    res_last_d   = 1'b0;
    res_ovf_d    = 1'b0;
    res_perr_d   = 1'b0;
    delta_x      = '0;
    sum_base     = '0;

    if (in_xfer) begin
      if (action == ACT_HEADER) begin
        rows_d       = hdr_cnt[WordW-1] ? RowCountMax : hdr_cnt[RowW-1:0];
        row_d        = '0;
        col_d        = '0;
        block_open_d = (hdr_cnt != '0);
        mag_d        = '0;
        bitpos_d     = '0;
        neg_d        = 1'b0;
        first_d      = 1'b1;
        ovf_d        = 1'b0;
      end else if (!block_open_q) begin
        res_load   = 1'b1;
        res_perr_d = 1'b1;
      end else begin
        if (first_q) begin
          neg_d    = word[c_m1];
          mag_d    = word & lo_mask;
          bitpos_d = BitPosW'(c_m1);
          ovf_d    = 1'b0;
          first_d  = 1'b0;
        end else begin
          if (bitpos_q >= BitPosMax) begin
            if (payload != '0) ovf_d = 1'b1;
          end else begin
            if (placed[2*WordW-1:WordW] != '0) ovf_d = 1'b1;
            mag_d = mag_q | placed[WordW-1:0];
          end
          bitpos_d = (bitpos_sum > (BitPosW+1)'(BitPosMax)) ?
                     BitPosMax : bitpos_sum[BitPosW-1:0];
        end

        if (stop) begin
          // two's complement negate folded into the add
          delta_x  = mag_d ^ {ValueW{neg_d}};
          sum_base = (row_q == '0) ? '0 : sum_q;
          sum_d    = sum_base + delta_x + ValueW'(neg_d);

          res_load    = 1'b1;
          res_value_d = sum_d;
          res_col_d   = col_ext[ColOutW-1:0];
          res_row_d   = row_q;
          res_last_d  = (col_q == ColLast) && row_end;
          res_ovf_d   = ovf_d;

          mag_d    = '0;
          bitpos_d = '0;
          neg_d    = 1'b0;
          first_d  = 1'b1;
          ovf_d    = 1'b0;

          if (row_end) begin
            row_d = '0;
            if (col_q == ColLast) begin
              col_d        = '0;
              block_open_d = 1'b0;
            end else begin
              col_d = col_q + ColW'(1);
            end
          end else begin
            row_d = row_inc[RowW-1:0];
          end
        end
      end
    end

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_bits_q <= ChunkBitsReset;
      block_open_q <= 1'b0;
      rows_q       <= '0;
      row_q        <= '0;
      col_q        <= '0;
      mag_q        <= '0;
      bitpos_q     <= '0;
      neg_q        <= 1'b0;
      first_q      <= 1'b1;
      ovf_q        <= 1'b0;
      sum_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        chunk_bits_q <= cfg_data_i;
      end
      block_open_q <= block_open_d;
      rows_q       <= rows_d;
      row_q        <= row_d;
      col_q        <= col_d;
      mag_q        <= mag_d;
      bitpos_q     <= bitpos_d;
      neg_q        <= neg_d;
      first_q      <= first_d;
      ovf_q        <= ovf_d;
      sum_q        <= sum_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_value_q <= res_value_d;
      res_col_q   <= res_col_d;
      res_row_q   <= res_row_d;
      res_last_q  <= res_last_d;
      res_ovf_q   <= res_ovf_d;
      res_perr_q  <= res_perr_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, res_row_q, res_col_q, res_value_q};
  assign m_axis_tlast  = res_last_q;
  assign m_axis_tuser  = {res_perr_q, res_ovf_q};

`ifndef SYNTH
  a_perr_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata == '0) && !m_axis_tlast && !m_axis_tuser[0])
    else $error("protocol error result carries data");

  a_open_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    block_open_q |-> (rows_q != '0) && (row_q < rows_q))
    else $error("open block with bad row state");

  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> (mag_q == '0) && (bitpos_q == '0) && !ovf_q)
    else $error("partial value left behind");

  a_bitpos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bitpos_q <= BitPosMax)
    else $error("bit position beyond saturation");

  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load && res_last_d |=> !block_open_q && (col_q == '0) && (row_q == '0))
    else $error("block still open after last value");
`endif

endmodule

`default_nettype wire
